// ----- design/gehm_pkg.sv -----
package gehm_pkg;

    localparam int NODE_W  = 12;
    localparam int SIZE_W  = 31;
    localparam int SCORE_W = 32;
    localparam int LIMIT_W = 13;
    localparam int CAP_W   = 31;
    localparam int ACC_W   = 13;
    localparam int REJ_W   = 40;

    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_USER_W = 3;
    localparam int OUT_DATA_W = 72;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register select is paddr[2]
    localparam logic REG_PAIR_LIMIT = 1'b0;
    localparam logic REG_SIZE_CAP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_CAND  = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OC_ACCEPTED    = 3'd0,
        OC_SIZE_REJECT = 3'd1,
        OC_MATCHED     = 3'd2,
        OC_LIMIT       = 3'd3,
        OC_INVALID     = 3'd4,
        OC_READ_DONE   = 3'd5,
        OC_LOADED      = 3'd6
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_B,
        ST_EVAL,
        ST_WR_B,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] pair_limit;
        logic [CAP_W-1:0]   size_cap;
    } t_cfg;

    typedef struct packed {
        t_outcome            outcome;
        logic [NODE_W-1:0]   partner;
        logic [ACC_W-1:0]    accepted;
        logic [REJ_W-1:0]    rejects;
    } t_result;

    typedef struct packed {
        logic clearing;
        logic flag_we;
    } t_core_stat;

endpackage

// ----- design/gehm_ram.sv -----
module gehm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/gehm_regs.sv -----
module gehm_regs
    import gehm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LIMIT_W-1:0] r_pair_limit;
    logic [CAP_W-1:0]   r_size_cap;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_limit <= '0;
            r_size_cap   <= CAP_W'(2);
        end else if (wr_en) begin
            case (paddr[2])
                REG_PAIR_LIMIT: r_pair_limit <= pwdata[LIMIT_W-1:0];
                REG_SIZE_CAP:   r_size_cap   <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PAIR_LIMIT: prdata = APB_DW'(r_pair_limit);
            REG_SIZE_CAP:   prdata = APB_DW'(r_size_cap);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.pair_limit = r_pair_limit;
    assign o_cfg.size_cap   = r_size_cap;

endmodule

// ----- design/gehm_core.sv -----
module gehm_core
    import gehm_pkg::*;
#(
    parameter int NODES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_mode             i_mode,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [SIZE_W-1:0] i_node_size,
    input  logic [SCORE_W-1:0] i_score,
    input  t_cfg              i_cfg,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output t_result           o_res,
    output t_core_stat        o_stat
);

    localparam int AW   = $clog2(NODES);
    localparam int FP_W = NODE_W + 1;   // {matched, partner}

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        return 32'(n) < 32'(NODES);
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_start, n_start;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [REJ_W-1:0]   r_rej, n_rej;

    logic [NODE_W-1:0]  r_a, n_a;
    logic [NODE_W-1:0]  r_b, n_b;
    logic               r_score_nz, n_score_nz;
    logic [SIZE_W-1:0]  r_size_a, n_size_a;
    logic               r_flag_a, n_flag_a;
    t_outcome           r_outcome, n_outcome;
    logic [NODE_W-1:0]  r_partner, n_partner;

    logic               sz_we;
    logic [SIZE_W-1:0]  sz_rdata;
    logic               fp_we;
    logic [AW-1:0]      fp_waddr;
    logic [FP_W-1:0]    fp_wdata;
    logic [FP_W-1:0]    fp_rdata;
    logic [AW-1:0]      rd_addr;

    logic               cand_invalid;
    logic               cand_limit;
    logic               cand_oversize;
    logic               cand_matched;
    logic [SIZE_W:0]    size_sum;

    gehm_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (AW'(i_node_a)),
        .i_wdata (i_node_size),
        .i_raddr (rd_addr),
        .o_rdata (sz_rdata)
    );

    gehm_ram #(.WIDTH(FP_W), .DEPTH(NODES)) u_match_ram (
        .i_clk   (i_clk),
        .i_we    (fp_we),
        .i_waddr (fp_waddr),
        .i_wdata (fp_wdata),
        .i_raddr (rd_addr),
        .o_rdata (fp_rdata)
    );

    // node A is read straight off the input beat, node B in the cycle after
    assign rd_addr = (r_state == ST_IDLE) ? AW'(i_node_a) : AW'(r_b);

    assign size_sum      = {1'b0, r_size_a} + {1'b0, sz_rdata};
    assign cand_invalid  = !r_score_nz || (r_a == r_b) || !in_range(r_a) || !in_range(r_b);
    assign cand_limit    = r_acc >= i_cfg.pair_limit;
    assign cand_oversize = size_sum > {1'b0, i_cfg.size_cap};
    assign cand_matched  = r_flag_a || fp_rdata[NODE_W];

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_start    = r_start;
        n_acc      = r_acc;
        n_rej      = r_rej;
        n_a        = r_a;
        n_b        = r_b;
        n_score_nz = r_score_nz;
        n_size_a   = r_size_a;
        n_flag_a   = r_flag_a;
        n_outcome  = r_outcome;
        n_partner  = r_partner;
        sz_we      = 1'b0;
        fp_we      = 1'b0;
        fp_waddr   = r_clr_addr;
        fp_wdata   = '0;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                fp_we = 1'b1;
                if (r_clr_addr == AW'(NODES - 1)) begin
                    n_clr_addr = '0;
                    n_start    = 1'b0;
                    n_outcome  = OC_LOADED;
                    n_state    = r_start ? ST_DONE : ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_a        = i_node_a;
                    n_b        = i_node_b;
                    n_score_nz = |i_score;
                    n_partner  = i_node_b;
                    case (i_mode)
                        MODE_START: begin
                            n_acc      = '0;
                            n_rej      = '0;
                            n_start    = 1'b1;
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        MODE_LOAD: begin
                            sz_we     = in_range(i_node_a);
                            n_outcome = in_range(i_node_a) ? OC_LOADED : OC_INVALID;
                            n_state   = ST_DONE;
                        end
                        MODE_CAND: n_state = ST_RD_B;
                        MODE_READ: n_state = ST_READ;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_B: begin
                n_size_a = sz_rdata;
                n_flag_a = fp_rdata[NODE_W];
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                if (cand_invalid) begin
                    n_outcome = OC_INVALID;
                end else if (cand_limit) begin
                    n_outcome = OC_LIMIT;
                end else if (cand_oversize) begin
                    n_outcome = OC_SIZE_REJECT;
                    if (r_rej != '1) begin
                        n_rej = r_rej + REJ_W'(1);
                    end
                end else if (cand_matched) begin
                    n_outcome = OC_MATCHED;
                end else begin
                    n_outcome = OC_ACCEPTED;
                    fp_we     = 1'b1;
                    fp_waddr  = AW'(r_a);
                    fp_wdata  = {1'b1, r_b};
                    if (r_acc != '1) begin
                        n_acc = r_acc + ACC_W'(1);
                    end
                    n_state = ST_WR_B;
                end
            end
            ST_WR_B: begin
                fp_we    = 1'b1;
                fp_waddr = AW'(r_b);
                fp_wdata = {1'b1, r_a};
                n_state  = ST_DONE;
            end
            ST_READ: begin
                n_outcome = OC_READ_DONE;
                n_partner = (in_range(r_a) && fp_rdata[NODE_W]) ?
                            fp_rdata[NODE_W-1:0] : r_a;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_start    <= 1'b0;
            r_acc      <= '0;
            r_rej      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_start    <= n_start;
            r_acc      <= n_acc;
            r_rej      <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_score_nz <= n_score_nz;
        r_size_a   <= n_size_a;
        r_flag_a   <= n_flag_a;
        r_outcome  <= n_outcome;
        r_partner  <= n_partner;
    end

    assign o_res.outcome  = r_outcome;
    assign o_res.partner  = r_partner;
    assign o_res.accepted = r_acc;
    assign o_res.rejects  = r_rej;

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_stat.flag_we  = fp_we;

endmodule

// ----- design/greedy_heavy_edge_matcher.sv -----
// Greedy heavy-edge pair matcher.
// Input stream (s_axis): one command per beat, kind in tuser (start pass, load
// node size, candidate edge, read partner). Candidates must arrive sorted by
// score. Output stream (m_axis): exactly one result beat per input beat, in
// order, carrying outcome, partner node, accepted-pair count and the
// saturating size-reject count as they stand after the command.
// APB port: pair limit at 0x0, summed size cap at 0x4; write only while idle.
// Steps, accept edge to result loaded into the output register:
//   load writes the size entry, read fetches the partner entry, candidate
//   evaluates after both endpoints; the single read port of the tables
//   means the two endpoints are fetched one after the other, and an accepted
//   pair writes both partner entries in turn. start: a one-entry-per-cycle
//   sweep of the matched-flag table.
// One command is in flight at a time; the next is taken the cycle after the
// result has moved into the output register, even if the receiver has not
// taken it.
// A stalled receiver holds the result beat; the engine then waits with its
// own result ready and takes no new beat.
// Reset: registers go to limit 0 and cap 2, counts to zero, and the flag
// table is swept clear (s_axis_tready low throughout).
module greedy_heavy_edge_matcher
    import gehm_pkg::*;
#(
    parameter int NODES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // node_a, node_b, node_size, candidate_score
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // mode
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // partner_node, accepted_pairs, size_rejects
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // outcome
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    t_cfg       cfg;
    t_result    core_res;
    t_core_stat core_stat;
    logic       core_res_valid;
    logic       out_free;

    logic       r_m_valid;
    t_result    r_m_res;

    gehm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gehm_core #(.NODES(NODES)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (t_mode'(s_axis_tuser)),
        .i_node_a    (s_axis_tdata[11:0]),
        .i_node_b    (s_axis_tdata[23:12]),
        .i_node_size (s_axis_tdata[54:24]),
        .i_score     (s_axis_tdata[86:55]),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .o_stat      (core_stat)
    );

    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid) begin
            r_m_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.outcome;
    assign m_axis_tdata  = {7'd0, r_m_res.rejects, r_m_res.accepted, r_m_res.partner};

`ifndef SYNTHESIS
    a_no_beat_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.clearing |-> !s_axis_tready)
        else $error("input taken during flag sweep");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat taken while engine busy");

    a_flag_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.flag_we |-> !s_axis_tready)
        else $error("flag table written while idle");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_res_valid |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a waiting beat");
`endif

endmodule
